// ===== hw/rtl/pdu_pkg.sv =====
`default_nettype none

package pdu_pkg;

  localparam logic [7:0] ESC_CHAR = 8'h25;
  localparam int         QDEPTH   = 8;
  localparam int         QCNT_W   = $clog2(QDEPTH + 1);
  localparam int         WIN      = 4;
  localparam int         HOLD     = WIN - 1;

  typedef struct packed {
    logic            last;
    logic [7:0]      data;
  } q_entry_t;

  typedef struct packed {
    logic [WIN-1:0][7:0]  res_byte;
    logic [2:0]           res_cnt;
    logic [HOLD-1:0][7:0] pend_byte;
    logic [1:0]           pend_cnt;
  } scan_t;

  // Bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b0, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = {1'b0, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = {1'b0, 4'(b - 8'h57)};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pdu_scan.sv =====
`default_nettype none

module pdu_scan (
  input  wire logic [pdu_pkg::HOLD-1:0][7:0] pend_byte,
  input  wire logic [1:0]                    pend_cnt,
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          in_last,
  output pdu_pkg::scan_t                     res
);

  logic [6:0][7:0] win;
  logic [2:0]      len;
  logic [2:0]      i;
  logic [2:0]      rem;
  logic [2:0]      n;
  logic            done;
  logic [4:0]      hex2;
  logic [4:0]      hex3;
  logic            ok_esc;
  logic            ok_hold;

  always_comb begin
    win = '0;
    for (int j = 0; j < pdu_pkg::HOLD; j++) begin
      if (2'(j) < pend_cnt) begin
        win[j] = pend_byte[j];
      end
    end
    win[3'(pend_cnt)] = in_byte;
    len     = 3'(pend_cnt) + 3'd1;
    i       = '0;
    n       = '0;
    done    = 1'b0;
    rem     = '0;
    hex2    = '0;
    hex3    = '0;
    ok_esc  = 1'b0;
    ok_hold = 1'b0;
    res     = '0;
    for (int k = 0; k < pdu_pkg::WIN; k++) begin
      if (!done && i < len) begin
        rem     = len - i;
        hex2    = pdu_pkg::hex_value(win[i + 3'd2]);
        hex3    = pdu_pkg::hex_value(win[i + 3'd3]);
        ok_esc  = rem == 3'd4 && win[i] == pdu_pkg::ESC_CHAR &&
                  win[i + 3'd1] == pdu_pkg::ESC_CHAR && !hex2[4] && !hex3[4];
        ok_hold = !in_last && rem < 3'd4 && win[i] == pdu_pkg::ESC_CHAR &&
                  (rem < 3'd2 || win[i + 3'd1] == pdu_pkg::ESC_CHAR) &&
                  (rem < 3'd3 || !hex2[4]);
        if (ok_esc) begin
          res.res_byte[n[1:0]] = {hex2[3:0], hex3[3:0]};
          n = n + 3'd1;
          i = i + 3'd4;
        end else if (ok_hold) begin
          for (int j = 0; j < pdu_pkg::HOLD; j++) begin
            if (3'(j) < rem) begin
              res.pend_byte[j] = win[i + 3'(j)];
            end
          end
          res.pend_cnt = rem[1:0];
          done = 1'b1;
        end else begin
          res.res_byte[n[1:0]] = win[i];
          n = n + 3'd1;
          i = i + 3'd1;
        end
      end
    end
    res.res_cnt = n;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pdu_rq.sv =====
`default_nettype none

module pdu_rq (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [2:0]                         push_cnt,
  input  wire pdu_pkg::q_entry_t [pdu_pkg::WIN-1:0] push_data,
  input  wire logic                               pop,
  output pdu_pkg::q_entry_t                       head,
  output logic                                    not_empty,
  output logic                                    room
);

  pdu_pkg::q_entry_t [pdu_pkg::QDEPTH-1:0] q_r;
  pdu_pkg::q_entry_t [pdu_pkg::QDEPTH-1:0] q_nxt;
  pdu_pkg::q_entry_t [pdu_pkg::QDEPTH-1:0] sh;
  logic [pdu_pkg::QCNT_W-1:0]              cnt_r;
  logic [pdu_pkg::QCNT_W-1:0]              cnt_nxt;
  logic [pdu_pkg::QCNT_W-1:0]              cnt_kept;
  logic [pdu_pkg::QCNT_W-1:0]              off;

  always_comb begin
    cnt_kept = cnt_r - pdu_pkg::QCNT_W'(pop);
    off      = '0;
    for (int e = 0; e < pdu_pkg::QDEPTH - 1; e++) begin
      sh[e] = pop ? q_r[e + 1] : q_r[e];
    end
    sh[pdu_pkg::QDEPTH-1] = q_r[pdu_pkg::QDEPTH-1];
    for (int e = 0; e < pdu_pkg::QDEPTH; e++) begin
      off      = pdu_pkg::QCNT_W'(e) - cnt_kept;
      q_nxt[e] = sh[e];
      if (pdu_pkg::QCNT_W'(e) >= cnt_kept && off < pdu_pkg::QCNT_W'(push_cnt)) begin
        q_nxt[e] = push_data[off[1:0]];
      end
    end
    cnt_nxt = cnt_kept + pdu_pkg::QCNT_W'(push_cnt);
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head      = q_r[0];
  assign not_empty = cnt_r != '0;
  assign room      = cnt_r <= pdu_pkg::QCNT_W'(pdu_pkg::QDEPTH - pdu_pkg::WIN);

  cnt_bound_a: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pdu_pkg::QCNT_W'(pdu_pkg::QDEPTH))
    else $error("result queue overfilled");

  pop_only_a: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push_cnt == 3'd0) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("result queue count lost a pop");

endmodule

`default_nettype wire

// ===== hw/rtl/double_percent_hex_unescaper_unit.sv =====
`default_nettype none

// Channel  Direction  tdata          tlast
// in_      slave      [7:0] byte     final byte of the string
// out_     master     [7:0] byte     final result byte of the string
//
// Each input item is decoded in the cycle it is accepted; its results are
// written into an eight-entry result queue and leave one per cycle while out_tready is high.
// One item can be taken every cycle while the queue has room for four results.
// Results are registered in the queue and reach the output from its head.
// Reset clears the held count and empties the queue.
// A stalled output only stops the input once the queue holds more than four items.

module double_percent_hex_unescaper_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast
);

  logic [pdu_pkg::HOLD-1:0][7:0]         pend_byte_r;
  logic [1:0]                            pend_cnt_r;
  pdu_pkg::scan_t                        scan;
  pdu_pkg::q_entry_t [pdu_pkg::WIN-1:0]  push_data;
  pdu_pkg::q_entry_t                     head;
  logic [2:0]                            push_cnt;
  logic                                  in_acc;
  logic                                  pop;

  assign in_acc = in_tvalid && in_tready;
  assign pop    = out_tvalid && out_tready;

  pdu_scan u_scan (
    .pend_byte (pend_byte_r),
    .pend_cnt  (pend_cnt_r),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .res       (scan)
  );

  always_comb begin
    for (int k = 0; k < pdu_pkg::WIN; k++) begin
      push_data[k].data = scan.res_byte[k];
      push_data[k].last = in_tlast && (3'(k) == scan.res_cnt - 3'd1);
    end
    push_cnt = in_acc ? scan.res_cnt : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_byte_r <= scan.pend_byte;
    end
    if (!rst_n) begin
      pend_cnt_r <= '0;
    end else if (in_acc) begin
      pend_cnt_r <= scan.pend_cnt;
    end
  end

  pdu_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (out_tvalid),
    .room      (in_tready)
  );

  assign out_tdata = head.data;
  assign out_tlast = head.last;

  last_clears_a: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> pend_cnt_r == 2'd0)
    else $error("held bytes survive the end of a string");

  last_yields_a: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |-> scan.res_cnt != 3'd0)
    else $error("final item produced no result");

  res_bound_a: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (scan.res_cnt <= 3'd4 &&
                3'(pend_cnt_r) + 3'd1 >= scan.res_cnt))
    else $error("more results than bytes in the window");

endmodule

`default_nettype wire
